>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry defaults
    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    // Field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 11;
    localparam int POS_W  = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE        = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE      = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_BLANK          = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE           = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_BLANK          = 8'h07;
    localparam logic [ATTR_W-1:0] ATTR_NONE           = 8'h00;
    localparam logic [ATTR_W-1:0] DEFAULT_COLOR_RESET = 8'h0F;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] color;
        logic [ADDR_W-1:0] cell_address;
    } tcw_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] cell_character;
        logic [ATTR_W-1:0] cell_attribute;
    } tcw_result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL,
        ST_BLANK_ROW,
        ST_PUT,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } tcw_state_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_BLANK,
        MEM_COPY,
        MEM_READ,
        MEM_PUT
    } tcw_mem_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } tcw_ptr_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_LASTROW,
        CUR_PUT
    } tcw_cur_op_t;

    // Controller to datapath
    typedef struct packed {
        logic        latch;
        tcw_mem_op_t mem_op;
        tcw_ptr_op_t ptr_op;
        tcw_cur_op_t cur_op;
    } tcw_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             char_zero;
        logic             at_end;
        logic             copy_last;
        logic             sweep_last;
    } tcw_status_t;

endpackage

>>> hw/rtl/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tcw_status_t status,
    output tcw_ctl_t    ctl,
    output logic        busy,
    output logic        done
);

    tcw_state_t state_reg;
    tcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.cmd)
                    CMD_PUT:
                    begin
                        if (status.char_zero)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (status.at_end)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    CMD_READ:  state_next = ST_READ;
                    CMD_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_SCROLL:
            begin
                if (status.copy_last)
                begin
                    state_next = ST_BLANK_ROW;
                end
            end
            ST_BLANK_ROW:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:  state_next = ST_DONE;
            ST_READ: state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.latch  = 1'b0;
        ctl.mem_op = MEM_NONE;
        ctl.ptr_op = PTR_HOLD;
        ctl.cur_op = CUR_HOLD;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.mem_op = MEM_BLANK;
                ctl.ptr_op = status.sweep_last ? PTR_ZERO : PTR_INC;
            end
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctl.latch = start;
            end
            ST_DECODE:
            begin
            end
            ST_SCROLL:
            begin
                ctl.mem_op = MEM_COPY;
                ctl.ptr_op = status.copy_last ? PTR_HOLD : PTR_INC;
            end
            ST_BLANK_ROW:
            begin
                ctl.mem_op = MEM_BLANK;
                if (status.sweep_last)
                begin
                    ctl.ptr_op = PTR_ZERO;
                    ctl.cur_op = CUR_LASTROW;
                end
                else
                begin
                    ctl.ptr_op = PTR_INC;
                end
            end
            ST_PUT:
            begin
                ctl.mem_op = MEM_PUT;
                ctl.cur_op = CUR_PUT;
            end
            ST_READ:
            begin
                ctl.mem_op = MEM_READ;
            end
            ST_CLEAR:
            begin
                ctl.mem_op = MEM_BLANK;
                if (status.sweep_last)
                begin
                    ctl.ptr_op = PTR_ZERO;
                    ctl.cur_op = CUR_HOME;
                end
                else
                begin
                    ctl.ptr_op = PTR_INC;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // One strobe per beat, then back to idle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    // An accepted beat keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("accepted beat did not start work");

endmodule

>>> hw/rtl/tcw_datapath.sv
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_item_t         item,
    input  logic              config_write,
    input  logic [ATTR_W-1:0] config_data,
    input  tcw_ctl_t          ctl,
    output tcw_status_t       status,
    output tcw_result_t       result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int KEEP  = CELLS - COLUMNS;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Latched item
    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [IW-1:0]     addr_reg;
    logic              addr_ok_reg;

    // Control state
    logic [ATTR_W-1:0] default_color_reg;
    logic [CW-1:0]     cursor_reg;
    logic [CW-1:0]     cursor_next;
    logic [COLW-1:0]   col_reg;
    logic [COLW-1:0]   col_next;
    logic [IW-1:0]     ptr_reg;
    logic [IW-1:0]     ptr_next;
    logic              rd_ok_reg;

    // Screen store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     cur_idx;

    assign cur_idx = IW'(cursor_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg     <= item.command;
            char_reg    <= item.character;
            attr_reg    <= (item.color != ATTR_NONE) ? item.color : default_color_reg;
            addr_reg    <= IW'(item.cell_address);
            addr_ok_reg <= 32'(item.cell_address) < CELLS;
        end
    end

    // Memory port decode
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = {CHAR_BLANK, ATTR_BLANK};
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        unique case (ctl.mem_op)
            MEM_NONE:
            begin
            end
            MEM_BLANK:
            begin
                wr_en = 1'b1;
            end
            MEM_COPY:
            begin
                // read one row ahead, write the cell read last cycle
                rd_en   = (ptr_reg != IW'(KEEP));
                rd_addr = ptr_reg + IW'(COLUMNS);
                wr_en   = (ptr_reg != '0);
                wr_addr = ptr_reg - IW'(1);
                wr_data = rd_data_reg;
            end
            MEM_READ:
            begin
                rd_en = addr_ok_reg;
            end
            MEM_PUT:
            begin
                case (char_reg)
                    CHAR_NEWLINE:
                    begin
                    end
                    CHAR_BACKSPACE:
                    begin
                        wr_en   = (cursor_reg != '0);
                        wr_addr = cur_idx - IW'(1);
                        wr_data = {CHAR_BLANK, attr_reg};
                    end
                    default:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = cur_idx;
                        wr_data = {char_reg, attr_reg};
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Cursor and column, column tracks cursor modulo COLUMNS
    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        unique case (ctl.cur_op)
            CUR_HOLD:
            begin
            end
            CUR_HOME:
            begin
                cursor_next = '0;
                col_next    = '0;
            end
            CUR_LASTROW:
            begin
                cursor_next = CW'(KEEP);
                col_next    = '0;
            end
            CUR_PUT:
            begin
                case (char_reg)
                    CHAR_NEWLINE:
                    begin
                        cursor_next = cursor_reg + (CW'(COLUMNS) - CW'(col_reg));
                        col_next    = '0;
                    end
                    CHAR_BACKSPACE:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - CW'(1);
                            col_next    = (col_reg == '0) ? COLW'(COLUMNS - 1)
                                                          : col_reg - COLW'(1);
                        end
                    end
                    default:
                    begin
                        cursor_next = cursor_reg + CW'(1);
                        col_next    = (col_reg == COLW'(COLUMNS - 1)) ? '0
                                                                      : col_reg + COLW'(1);
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        unique case (ctl.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + IW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
            cursor_reg        <= '0;
            col_reg           <= '0;
            ptr_reg           <= '0;
            rd_ok_reg         <= 1'b0;
        end
        else
        begin
            if (config_write)
            begin
                default_color_reg <= config_data;
            end
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            ptr_reg    <= ptr_next;
            if (ctl.latch)
            begin
                rd_ok_reg <= 1'b0;
            end
            else if (ctl.mem_op == MEM_READ)
            begin
                rd_ok_reg <= addr_ok_reg;
            end
        end
    end

    assign status.cmd        = cmd_reg;
    assign status.char_zero  = (char_reg == CHAR_NONE);
    assign status.at_end     = (cursor_reg >= CW'(CELLS));
    assign status.copy_last  = (ptr_reg == IW'(KEEP));
    assign status.sweep_last = (ptr_reg == IW'(CELLS - 1));

    assign result.cursor_position = POS_W'(cursor_reg);
    assign result.cell_character  = rd_ok_reg ? rd_data_reg[CELL_W-1:ATTR_W] : CHAR_NONE;
    assign result.cell_attribute  = rd_ok_reg ? rd_data_reg[ATTR_W-1:0] : ATTR_NONE;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(CELLS) && 32'(col_reg) < COLUMNS)
        else $error("cursor or column out of range");

    a_put_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mem_op == MEM_PUT) |-> !status.at_end)
        else $error("put issued with cursor past the screen");

    a_blank_row_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cur_op == CUR_LASTROW) |-> (ctl.mem_op == MEM_BLANK && status.sweep_last))
        else $error("cursor moved to last row before the row was blanked");

endmodule

>>> hw/rtl/text_console_writer.sv
// Channel   Handshake              Payload                  Direction
// item      start high, busy low   item (tcw_item_t)        in
// result    done, one cycle        result (tcw_result_t)    out
// config    config_write           config_data (8 bits)     in
//
// A read or a put of a nonzero character goes from accept to the next accept through
// decode, one store access, one cycle with done high, then idle.
// A put of character zero or an unused command skips the store access.
// A clear walks the screen store one cell a cycle.
// A put that scrolls first moves every row up by one and blanks the bottom row.
// After reset busy holds high for the clearing pass over all COLUMNS*ROWS cells (config
// writes are taken during it). The receiver cannot stall results.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcw_item_t         item,
    output logic              done,
    output tcw_result_t       result,
    input  logic              config_write,
    input  logic [ATTR_W-1:0] config_data
);

    tcw_ctl_t    ctl;
    tcw_status_t status;

    // Sequence each beat: decode, scroll or clear sweeps, store access, result
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    // Hold the screen store, cursor, sweep pointer and default color
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .config_write (config_write),
        .config_data  (config_data),
        .ctl          (ctl),
        .status       (status),
        .result       (result)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int COLS  = TCW_COLUMNS;
    localparam int CELLS = TCW_COLUMNS * TCW_ROWS;
    localparam int ADDR_MAX = 2 ** ADDR_W - 1;

    // Command code 3 is not decoded by the block; it must still answer with the cursor
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // A scroll or a clear walks the whole store; allow several times as long as such a walk
    localparam int STALL_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 4;
    localparam int PHASE_BEATS   = 250;
    localparam int REPORT_LIMIT  = 10;

    // One row of the directed script: repeat count, whether the result is typed in
    // here (pinned) or taken from the shadow console, the beat and the pinned result
    typedef struct packed {
        logic [5:0]  reps;
        logic        pinned;
        tcw_item_t   beat;
        tcw_result_t want;
    } script_row_t;

    localparam tcw_result_t NO_WANT = '0;
    localparam int SCRIPT_LEN = 25;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // fresh screen: every cell is a blank with the blank attribute
        '{6'd1, 1'b1, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd0},
            '{11'd0, CHAR_BLANK, ATTR_BLANK}},
        '{6'd1, 1'b1, '{CMD_READ, 8'hFF, 8'hFF, 11'd1999},
            '{11'd0, CHAR_BLANK, ATTR_BLANK}},
        // read past the last cell returns zeros
        '{6'd1, 1'b1, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd2047},
            '{11'd0, CHAR_NONE, ATTR_NONE}},
        // undecoded command changes nothing
        '{6'd1, 1'b1, '{CMD_UNUSED, 8'hFF, 8'hFF, 11'd2047},
            '{11'd0, CHAR_NONE, ATTR_NONE}},
        // backspace at home and a zero character are both no-ops
        '{6'd1, 1'b1, '{CMD_PUT, CHAR_BACKSPACE, 8'hFF, 11'd0},
            '{11'd0, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_PUT, CHAR_NONE, 8'hAB, 11'd0},
            '{11'd0, CHAR_NONE, ATTR_NONE}},
        // color zero picks up the default color register
        '{6'd1, 1'b1, '{CMD_PUT, 8'h41, ATTR_NONE, 11'd0},
            '{11'd1, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd0},
            '{11'd1, 8'h41, DEFAULT_COLOR_RESET}},
        '{6'd1, 1'b1, '{CMD_PUT, 8'hFF, 8'hFF, 11'd2047},
            '{11'd2, CHAR_NONE, ATTR_NONE}},
        // backspace blanks the cell with the put's own color
        '{6'd1, 1'b1, '{CMD_PUT, CHAR_BACKSPACE, 8'h5A, 11'd0},
            '{11'd1, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd1},
            '{11'd1, CHAR_BLANK, 8'h5A}},
        '{6'd1, 1'b1, '{CMD_PUT, CHAR_NEWLINE, ATTR_NONE, 11'd0},
            '{11'd80, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_PUT, 8'h01, 8'h80, 11'd0},
            '{11'd81, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_CLEAR, 8'hFF, 8'hFF, 11'd2047},
            '{11'd0, CHAR_NONE, ATTR_NONE}},
        '{6'd1, 1'b1, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd0},
            '{11'd0, CHAR_BLANK, ATTR_BLANK}},
        // run the cursor down to the end of the screen
        '{6'd25, 1'b0, '{CMD_PUT, CHAR_NEWLINE, ATTR_NONE, 11'd0}, NO_WANT},
        // a pending scroll comes first, then the write
        '{6'd1, 1'b0, '{CMD_PUT, 8'h5A, 8'h33, 11'd0}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd1920}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_PUT, CHAR_NEWLINE, ATTR_NONE, 11'd0}, NO_WANT},
        // zero character at the end of the screen must not scroll
        '{6'd1, 1'b0, '{CMD_PUT, CHAR_NONE, 8'h44, 11'd0}, NO_WANT},
        // newline at the end scrolls and lands on the end again
        '{6'd1, 1'b0, '{CMD_PUT, CHAR_NEWLINE, 8'h12, 11'd0}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_PUT, CHAR_BACKSPACE, 8'h66, 11'd0}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd1919}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_READ, CHAR_NONE, ATTR_NONE, 11'd1840}, NO_WANT},
        '{6'd1, 1'b0, '{CMD_PUT, 8'h7E, ATTR_NONE, 11'd0}, NO_WANT}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    tcw_item_t         item;
    logic              done;
    tcw_result_t       result;
    logic              config_write;
    logic [ATTR_W-1:0] config_data;

    // Shadow console: screen store, cursor and default color as the block should hold them
    logic [CHAR_W-1:0] shadow_char [CELLS];
    logic [ATTR_W-1:0] shadow_attr [CELLS];
    int unsigned       shadow_cursor;
    logic [ATTR_W-1:0] shadow_default;

    tcw_result_t pending_results [$];

    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned scroll_count;
    int unsigned color_settings;
    int unsigned beats_by_command [4];
    int unsigned stall_cycles;

    text_console_writer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .done         (done),
        .result       (result),
        .config_write (config_write),
        .config_data  (config_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Blank every cell and home the cursor
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_char[i] = CHAR_BLANK;
            shadow_attr[i] = ATTR_BLANK;
        end
        shadow_cursor = 0;
    endfunction

    // Apply one beat to the shadow console and return the result the block owes for it
    function automatic tcw_result_t console_step(input tcw_item_t beat);
        tcw_result_t       outcome;
        logic [ATTR_W-1:0] attr;
        outcome = '0;
        attr = (beat.color != ATTR_NONE) ? beat.color : shadow_default;
        case (beat.command)
            CMD_PUT:
                if (beat.character != CHAR_NONE)
                begin
                    if (shadow_cursor >= CELLS)
                    begin
                        // move every row up by one, blank the bottom row, park at its start
                        for (int i = 0; i < CELLS - COLS; i++)
                        begin
                            shadow_char[i] = shadow_char[i + COLS];
                            shadow_attr[i] = shadow_attr[i + COLS];
                        end
                        for (int i = CELLS - COLS; i < CELLS; i++)
                        begin
                            shadow_char[i] = CHAR_BLANK;
                            shadow_attr[i] = ATTR_BLANK;
                        end
                        shadow_cursor = CELLS - COLS;
                        scroll_count++;
                    end
                    if (beat.character == CHAR_NEWLINE)
                    begin
                        shadow_cursor += COLS - shadow_cursor % COLS;
                    end
                    else if (beat.character == CHAR_BACKSPACE)
                    begin
                        if (shadow_cursor > 0)
                        begin
                            shadow_cursor--;
                            shadow_char[shadow_cursor] = CHAR_BLANK;
                            shadow_attr[shadow_cursor] = attr;
                        end
                    end
                    else
                    begin
                        shadow_char[shadow_cursor] = beat.character;
                        shadow_attr[shadow_cursor] = attr;
                        shadow_cursor++;
                    end
                end
            CMD_READ:
                if (beat.cell_address < CELLS)
                begin
                    outcome.cell_character = shadow_char[beat.cell_address];
                    outcome.cell_attribute = shadow_attr[beat.cell_address];
                end
            CMD_CLEAR:
                blank_screen();
            default:
                ;
        endcase
        outcome.cursor_position = POS_W'(shadow_cursor);
        return outcome;
    endfunction

    // Draw a random beat: mostly puts of text with newlines and backspaces mixed in, reads,
    // mostly aimed at freshly written cells, and now and then a clear or junk command
    function automatic tcw_item_t random_beat();
        tcw_item_t   beat;
        int unsigned pick;
        beat.command      = CMD_PUT;
        beat.character    = CHAR_W'($urandom_range(255));
        beat.color        = ($urandom_range(3) == 0) ? ATTR_NONE : ATTR_W'($urandom_range(255));
        beat.cell_address = ADDR_W'($urandom_range(ADDR_MAX));
        pick = $urandom_range(99);
        if (pick < 52)
        begin
            // keep the random character code
        end
        else if (pick < 62)
        begin
            beat.character = CHAR_NEWLINE;
        end
        else if (pick < 69)
        begin
            beat.character = CHAR_BACKSPACE;
        end
        else if (pick < 72)
        begin
            beat.character = CHAR_NONE;
        end
        else if (pick < 94)
        begin
            beat.command = CMD_READ;
            if (pick < 84)
                beat.cell_address = ADDR_W'((shadow_cursor > 4) ?
                                            shadow_cursor - 1 - $urandom_range(3) : 0);
            else if (pick < 91)
                beat.cell_address = ADDR_W'($urandom_range(CELLS - 1));
            else
                beat.cell_address = ADDR_W'($urandom_range(ADDR_MAX, CELLS));
        end
        else if (pick < 96)
        begin
            beat.command = CMD_CLEAR;
        end
        else
        begin
            beat.command = CMD_UNUSED;
        end
        return beat;
    endfunction

    // Present a beat and hold it until an edge sees start high with busy low.
    // Called right after a rising edge; returns at the accepting edge with start still high.
    task automatic send_beat(input tcw_item_t beat, input bit pinned, input tcw_result_t want);
        tcw_result_t predicted;
        item  <= beat;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = console_step(beat);
        pending_results.push_back(pinned ? want : predicted);
        beats_by_command[beat.command]++;
    endtask

    // Drop start, let every owed result arrive, then give the block time to settle
    task automatic wait_for_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_default_color(input logic [ATTR_W-1:0] value);
        config_write <= 1'b1;
        config_data  <= value;
        @(posedge clk);
        config_write <= 1'b0;
        shadow_default = value;
        color_settings++;
    endtask

    task automatic report_mismatch(input string what, input tcw_result_t want,
                                   input tcw_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch (%s): expected cursor %0d char %02h attr %02h, got cursor %0d char %02h attr %02h",
                     what, want.cursor_position, want.cell_character, want.cell_attribute,
                     got.cursor_position, got.cell_character, got.cell_attribute);
    endtask

    // Result checker: a beat is on the result ports for the cycle that ends at this edge
    always @(posedge clk)
    begin : check_results
        tcw_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("no beat pending", NO_WANT, result);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result.cursor_position !== want.cursor_position ||
                    result.cell_character !== want.cell_character ||
                    result.cell_attribute !== want.cell_attribute)
                    report_mismatch("field", want, result);
            end
        end
    end

    // Watchdog: any accept on either side restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [ATTR_W-1:0] phase_color [PHASES];
        int                idle_pct [PHASES];

        // Drive every input to a known value with reset held
        rst_n        <= 1'b0;
        start        <= 1'b0;
        item         <= '0;
        config_write <= 1'b0;
        config_data  <= '0;
        blank_screen();
        shadow_default = DEFAULT_COLOR_RESET;
        mismatch_count = 0;
        results_checked = 0;
        scroll_count = 0;
        color_settings = 1;
        stall_cycles = 0;
        foreach (beats_by_command[i])
            beats_by_command[i] = 0;

        // Default color extremes first, then a random one and 80h; the second and last phases run flat out
        phase_color = '{8'hFF, ATTR_NONE, ATTR_W'($urandom_range(254, 1)), 8'h80};
        idle_pct    = '{30, 0, 45, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed script; the block is busy with its clearing pass first, so just wait on busy
        foreach (SCRIPT[r])
            for (int n = 0; n < SCRIPT[r].reps; n++)
                send_beat(SCRIPT[r].beat, SCRIPT[r].pinned, SCRIPT[r].want);

        // Random phases, each behind a full drain and a fresh default color
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_idle();
            set_default_color(phase_color[p]);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_beat(random_beat(), 1'b0, NO_WANT);
                if ($urandom_range(99) < idle_pct[p])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(13, 1)) @(posedge clk);
                end
            end
        end

        wait_for_idle();

        $display("Checked %0d results: %0d puts, %0d reads, %0d clears, %0d undecoded commands",
                 results_checked, beats_by_command[CMD_PUT], beats_by_command[CMD_READ],
                 beats_by_command[CMD_CLEAR], beats_by_command[CMD_UNUSED]);
        $display("Screen scrolled %0d times across %0d default color settings",
                 scroll_count, color_settings);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer.sv
bench/tb_top.sv
